/* design/dfs_maze_walker_step_unit_assert.svh */
// Assertion macros shared by the checker of the maze walker step unit.
`ifndef DFS_MAZE_WALKER_STEP_UNIT_ASSERT_SVH
`define DFS_MAZE_WALKER_STEP_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled during rst.
`define DMWS_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled during rst.
`define DMWS_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

/* design/dmws_pkg.sv */
// Shared request, direction and move codes of the maze walker step unit.
`default_nettype none

package dmws_pkg;

  // Request codes of an input word.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;

  // Directions, in the order a step tries them.
  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // Kinds of move reported in a result word.
  localparam logic [1:0] MK_NONE  = 2'd0;
  localparam logic [1:0] MK_FWD   = 2'd1;
  localparam logic [1:0] MK_BACK  = 2'd2;
  localparam logic [1:0] MK_STUCK = 2'd3;

endpackage

`default_nettype wire

/* design/dmws_nbr.sv */
// Neighbour unit: steps one cell from a position and flags moves off the grid.
`default_nettype none

module dmws_nbr #(
  parameter int GRID_SIZE = 32,
  localparam int CW = $clog2(GRID_SIZE)
) (
  input  wire logic [1:0]    dir,
  input  wire logic [CW-1:0] cx,
  input  wire logic [CW-1:0] cy,
  output logic               ok,
  output logic [CW-1:0]      nx,
  output logic [CW-1:0]      ny
);

  always_comb begin
    ok = 1'b1;
    nx = cx;
    ny = cy;
    unique case (dir)
      dmws_pkg::DIR_DOWN: begin
        if ((CW+1)'(cy) + (CW+1)'(1) >= (CW+1)'(GRID_SIZE)) begin
          ok = 1'b0;
        end else begin
          ny = cy + CW'(1);
        end
      end
      dmws_pkg::DIR_RIGHT: begin
        if ((CW+1)'(cx) + (CW+1)'(1) >= (CW+1)'(GRID_SIZE)) begin
          ok = 1'b0;
        end else begin
          nx = cx + CW'(1);
        end
      end
      dmws_pkg::DIR_UP: begin
        if (cy == '0) begin
          ok = 1'b0;
        end else begin
          ny = cy - CW'(1);
        end
      end
      dmws_pkg::DIR_LEFT: begin
        if (cx == '0) begin
          ok = 1'b0;
        end else begin
          nx = cx - CW'(1);
        end
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/dfs_maze_walker_step_unit.sv */
// Top level of the depth-first maze walker: maps, direction stack and step sequencer.
`default_nettype none

// The walker holds a GRID_SIZE x GRID_SIZE open map, a visited map kept as one
// row per memory word, and a direction stack, all in single-port memories with
// registered reads. Words are taken one at a time: in_ready is high only while
// the sequencer is idle, and a finished result waits in the output register
// while the next word is accepted. A step probes the neighbours through one
// shared neighbour unit: an off-grid neighbour is skipped without a memory
// read, an on-grid one is read from memory and then checked, a backtrack
// adds a read of the direction stack, and a stuck step ends after the test
// for an empty stack. A start clears the visited map one row per cycle.
// After reset the same clearing pass runs before the first word is accepted.
module dfs_maze_walker_step_unit #(
  parameter int GRID_SIZE = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] req_type,
  input  wire logic [4:0] cell_x,
  input  wire logic [4:0] cell_y,
  input  wire logic       passable,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      pos_x,
  output logic [4:0]      pos_y,
  output logic [1:0]      move_kind,
  output logic [1:0]      move_dir,
  output logic [10:0]     depth
);

  localparam int CW    = $clog2(GRID_SIZE);
  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_BACK  = 3'd4;
  localparam logic [2:0] S_UNDO  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]      state;
  logic [CW-1:0]   clr_row;
  logic            clr_report;
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] count_m1;
  logic [CW-1:0]   cur_x;
  logic [CW-1:0]   cur_y;
  logic [1:0]      probe_dir;
  logic [CW-1:0]   px;
  logic [CW-1:0]   py;
  logic [1:0]      res_kind;
  logic [1:0]      res_dir;

  logic                 open_map [CELLS];
  logic [GRID_SIZE-1:0] seen_map [GRID_SIZE];
  logic [1:0]           dir_stack [CELLS];

  logic                 open_q;
  logic [GRID_SIZE-1:0] row_q;
  logic [1:0]           stk_q;

  logic                 in_fire;
  logic                 load_in_grid;
  logic                 open_we;
  logic [AW-1:0]        open_wa;
  logic                 seen_we;
  logic [CW-1:0]        seen_wa;
  logic [GRID_SIZE-1:0] seen_wd;
  logic                 hit;
  logic                 push;
  logic [1:0]           nbr_dir;
  logic                 n_ok;
  logic [CW-1:0]        n_x;
  logic [CW-1:0]        n_y;
  logic [AW-1:0]        n_addr;

  function automatic logic [CW-1:0] sat_coord(input logic [4:0] v);
    logic [CW-1:0] r;
    if (int'(v) >= GRID_SIZE) begin
      r = CW'(GRID_SIZE - 1);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign count_m1 = count - CNTW'(1);

  // The one neighbour unit serves both the forward probes and the backtrack.
  assign nbr_dir = (state == S_UNDO) ? stk_q + 2'd2 : probe_dir;

  dmws_nbr #(
    .GRID_SIZE(GRID_SIZE)
  ) u_nbr (
    .dir(nbr_dir),
    .cx (cur_x),
    .cy (cur_y),
    .ok (n_ok),
    .nx (n_x),
    .ny (n_y)
  );

  assign n_addr = AW'(n_y) * AW'(GRID_SIZE) + AW'(n_x);

  assign load_in_grid = (int'(cell_x) < GRID_SIZE) && (int'(cell_y) < GRID_SIZE);
  assign open_we      = in_fire && (req_type == dmws_pkg::REQ_LOAD) && load_in_grid;
  assign open_wa      = AW'(cell_y) * AW'(GRID_SIZE) + AW'(cell_x);

  assign hit  = open_q && !row_q[px];
  assign push = (state == S_CHECK) && hit && (count < CNTW'(CELLS));

  always_comb begin
    seen_we = 1'b0;
    seen_wa = py;
    seen_wd = row_q | ({{(GRID_SIZE-1){1'b0}}, 1'b1} << px);
    if (state == S_CLEAR) begin
      seen_we = 1'b1;
      seen_wa = clr_row;
      seen_wd = '0;
    end else if (state == S_CHECK && hit) begin
      seen_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (open_we) begin
      open_map[open_wa] <= passable;
    end
    if (state == S_PROBE && n_ok) begin
      open_q <= open_map[n_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_map[seen_wa] <= seen_wd;
    end
    if (state == S_PROBE && n_ok) begin
      row_q <= seen_map[n_y];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      dir_stack[count[AW-1:0]] <= probe_dir;
    end
    if (state == S_BACK && count != '0) begin
      stk_q <= dir_stack[count_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_row    <= '0;
      clr_report <= 1'b0;
      count      <= '0;
      cur_x      <= '0;
      cur_y      <= '0;
      probe_dir  <= dmws_pkg::DIR_DOWN;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            probe_dir <= dmws_pkg::DIR_DOWN;
            res_kind  <= dmws_pkg::MK_NONE;
            res_dir   <= dmws_pkg::DIR_DOWN;
            if (req_type == dmws_pkg::REQ_START) begin
              cur_x      <= sat_coord(cell_x);
              cur_y      <= sat_coord(cell_y);
              count      <= '0;
              clr_row    <= '0;
              clr_report <= 1'b1;
              state      <= S_CLEAR;
            end else if (req_type == dmws_pkg::REQ_STEP) begin
              state <= S_PROBE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_CLEAR: begin
          clr_row <= clr_row + CW'(1);
          if (clr_row == CW'(GRID_SIZE - 1)) begin
            clr_report <= 1'b0;
            state      <= clr_report ? S_DONE : S_IDLE;
          end
        end
        S_PROBE: begin
          if (n_ok) begin
            px    <= n_x;
            py    <= n_y;
            state <= S_CHECK;
          end else if (probe_dir == dmws_pkg::DIR_LEFT) begin
            state <= S_BACK;
          end else begin
            probe_dir <= probe_dir + 2'd1;
          end
        end
        S_CHECK: begin
          if (hit) begin
            cur_x    <= px;
            cur_y    <= py;
            res_kind <= dmws_pkg::MK_FWD;
            res_dir  <= probe_dir;
            if (push) begin
              count <= count + CNTW'(1);
            end
            state <= S_DONE;
          end else if (probe_dir == dmws_pkg::DIR_LEFT) begin
            state <= S_BACK;
          end else begin
            probe_dir <= probe_dir + 2'd1;
            state     <= S_PROBE;
          end
        end
        S_BACK: begin
          if (count == '0) begin
            res_kind <= dmws_pkg::MK_STUCK;
            state    <= S_DONE;
          end else begin
            count <= count_m1;
            state <= S_UNDO;
          end
        end
        S_UNDO: begin
          // A backtrack that would leave the grid keeps the position.
          if (n_ok) begin
            cur_x <= n_x;
            cur_y <= n_y;
          end
          res_kind <= dmws_pkg::MK_BACK;
          res_dir  <= nbr_dir;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            pos_x     <= 5'(cur_x);
            pos_y     <= 5'(cur_y);
            move_kind <= res_kind;
            move_dir  <= res_dir;
            depth     <= 11'(count);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/dmws_checker.sv */
// Port-level checker of the maze walker step unit and its bind statement.
`default_nettype none

`include "dfs_maze_walker_step_unit_assert.svh"

module dmws_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  move_kind,
  input wire logic [1:0]  move_dir,
  input wire logic [10:0] depth
);

  // A result word stays offered until it is taken.
  `DMWS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")

  // Every accepted word makes the walker busy, so in_ready drops after each accept.
  `DMWS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  // Without a move there is no direction to report.
  `DMWS_ASSERT_IMP(a_dir_idle,
    out_valid && (move_kind == dmws_pkg::MK_NONE || move_kind == dmws_pkg::MK_STUCK),
    move_dir == dmws_pkg::DIR_DOWN, "direction set without a move")

  // The walker is only stuck when the stack is empty.
  `DMWS_ASSERT_IMP(a_stuck_empty, out_valid && move_kind == dmws_pkg::MK_STUCK,
    depth == 11'd0, "stuck with a nonempty stack")

endmodule

bind dfs_maze_walker_step_unit dmws_checker u_dmws_checker (.*);

`default_nettype wire
